>>> rtl/upd_pkg.sv
// Shared types, character codes and hex lookup for the URL percent decoder.
// No dependencies; used by upd_front, upd_back and the top level.
package upd_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SPACE   = 8'h20;

  // One classified input byte: up to three candidate output bytes.
  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      cnt;
    logic            last;
  } entry_t;

  // Bit 4 set: not a hex digit. Bits 3:0: nibble value.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'b10000;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, 4'(c[3:0] + 4'd9)};
    end
    return v;
  endfunction

  function automatic logic [7:0] plain_byte(input logic [7:0] b);
    return (b == CH_PLUS) ? CH_SPACE : b;
  endfunction

endpackage

>>> rtl/upd_fifo.sv
// Small register queue between the decoder front and back.
// Generic width and depth; no package dependency.
module upd_fifo #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty,
  output logic             full
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  assign empty    = (count_r == '0);
  assign full     = (count_r == CW'(DEPTH));
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> rtl/upd_front.sv
// Decoder front: accepts input bytes, tracks pending escapes, and turns each
// byte that yields output or ends a stream into a queue entry. Uses upd_pkg.
module upd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  logic [7:0]      in_byte,
  input  logic            in_last,
  input  logic            q_full,
  output logic            push,
  output upd_pkg::entry_t push_entry
);

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_PCT  = 2'd1;
  localparam logic [1:0] PEND_DIG  = 2'd2;

  logic [1:0]      pend_r, pend_nxt;
  logic [7:0]      held_r, held_nxt;
  logic [4:0]      hb, hh;
  logic [2:0][7:0] slots;
  logic [1:0]      n;
  logic            accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    slots    = '0;
    n        = 2'd0;
    pend_nxt = pend_r;
    held_nxt = held_r;
    hb       = upd_pkg::hex_value(in_byte);
    hh       = upd_pkg::hex_value(held_r);
    case (pend_r)
      PEND_NONE: begin
        if (in_byte == upd_pkg::CH_PERCENT) begin
          pend_nxt = PEND_PCT;
        end else begin
          slots[n] = upd_pkg::plain_byte(in_byte);
          n = n + 2'd1;
        end
      end
      PEND_PCT: begin
        if (!hb[4]) begin
          held_nxt = in_byte;
          pend_nxt = PEND_DIG;
        end else begin
          pend_nxt = PEND_NONE;
          slots[n] = upd_pkg::CH_PERCENT;
          n = n + 2'd1;
          if (in_byte == upd_pkg::CH_PERCENT) begin
            pend_nxt = PEND_PCT;
          end else begin
            slots[n] = upd_pkg::plain_byte(in_byte);
            n = n + 2'd1;
          end
        end
      end
      default: begin
        pend_nxt = PEND_NONE;
        if (!hb[4]) begin
          slots[n] = {hh[3:0], hb[3:0]};
          n = n + 2'd1;
        end else begin
          slots[n] = upd_pkg::CH_PERCENT;
          n = n + 2'd1;
          slots[n] = held_r;
          n = n + 2'd1;
          if (in_byte == upd_pkg::CH_PERCENT) begin
            pend_nxt = PEND_PCT;
          end else begin
            slots[n] = upd_pkg::plain_byte(in_byte);
            n = n + 2'd1;
          end
        end
      end
    endcase
    if (in_last) begin
      if (pend_nxt != PEND_NONE) begin
        slots[n] = upd_pkg::CH_PERCENT;
        n = n + 2'd1;
      end
      if (pend_nxt == PEND_DIG) begin
        slots[n] = held_nxt;
        n = n + 2'd1;
      end
      pend_nxt = PEND_NONE;
      held_nxt = 8'd0;
    end
  end

  assign push             = accept && ((n != 2'd0) || in_last);
  assign push_entry.bytes = slots;
  assign push_entry.cnt   = n;
  assign push_entry.last  = in_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= PEND_NONE;
      held_r <= 8'd0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      held_r <= held_nxt;
    end
  end

endmodule

>>> rtl/upd_back.sv
// Decoder back: drains entries one candidate byte per cycle unless stalled,
// applies output capacity, drives the registered result channel. Uses upd_pkg.
module upd_back (
  input  logic            clk,
  input  logic            rst_n,
  input  upd_pkg::entry_t head,
  input  logic            q_empty,
  output logic            pop,
  input  logic [15:0]     capacity,
  output logic            out_item_valid,
  input  logic            out_stall,
  output logic [7:0]      out_byte,
  output logic            out_valid,
  output logic            out_last,
  output logic            out_overflow,
  output logic [15:0]     out_length
);

  logic [1:0]  k_r, k_nxt;
  logic [15:0] count_r, count_nxt;
  logic        ovf_r, ovf_nxt;

  logic        oitem_r, oitem_nxt;
  logic [7:0]  obyte_r;
  logic        ovalid_r, olast_r, oovf_r;
  logic [15:0] olen_r;

  logic        ld_ok, load;
  logic        r_vld, r_last, r_ovf;
  logic [7:0]  r_byte;
  logic [15:0] r_len;
  logic [7:0]  cur;
  logic        last_slot, emit_ok, fin;
  logic [15:0] cnt_inc;

  always_comb begin
    k_nxt     = k_r;
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    pop       = 1'b0;
    load      = 1'b0;
    r_vld     = 1'b0;
    r_byte    = 8'd0;
    r_last    = 1'b0;
    r_ovf     = 1'b0;
    r_len     = 16'd0;
    fin       = 1'b0;
    ld_ok     = !oitem_r || !out_stall;
    cur       = head.bytes[k_r];
    last_slot = (k_r == head.cnt - 2'd1);
    emit_ok   = !ovf_r && (count_r < capacity);
    cnt_inc   = count_r + 16'd1;
    if (!q_empty && ld_ok) begin
      if (head.cnt == 2'd0) begin
        load   = 1'b1;
        r_last = 1'b1;
        r_ovf  = ovf_r;
        r_len  = ovf_r ? 16'd0 : count_r;
        pop    = 1'b1;
        k_nxt  = 2'd0;
        count_nxt = 16'd0;
        ovf_nxt   = 1'b0;
      end else if (emit_ok) begin
        load   = 1'b1;
        r_vld  = 1'b1;
        r_byte = cur;
        fin    = head.last && (last_slot || (cnt_inc == capacity));
        if (fin) begin
          r_last    = 1'b1;
          r_ovf     = !last_slot;
          r_len     = last_slot ? cnt_inc : 16'd0;
          pop       = 1'b1;
          k_nxt     = 2'd0;
          count_nxt = 16'd0;
          ovf_nxt   = 1'b0;
        end else begin
          count_nxt = cnt_inc;
          if (last_slot) begin
            pop   = 1'b1;
            k_nxt = 2'd0;
          end else begin
            k_nxt = k_r + 2'd1;
          end
        end
      end else if (head.last) begin
        load      = 1'b1;
        r_last    = 1'b1;
        r_ovf     = 1'b1;
        pop       = 1'b1;
        k_nxt     = 2'd0;
        count_nxt = 16'd0;
        ovf_nxt   = 1'b0;
      end else begin
        // capacity hit: drop the rest of this entry
        ovf_nxt = 1'b1;
        pop     = 1'b1;
        k_nxt   = 2'd0;
      end
    end
    oitem_nxt = oitem_r;
    if (load) begin
      oitem_nxt = 1'b1;
    end else if (!out_stall) begin
      oitem_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= 2'd0;
      count_r <= 16'd0;
      ovf_r   <= 1'b0;
      oitem_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      oitem_r <= oitem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte_r  <= r_byte;
      ovalid_r <= r_vld;
      olast_r  <= r_last;
      oovf_r   <= r_ovf;
      olen_r   <= r_len;
    end
  end

  assign out_item_valid = oitem_r;
  assign out_byte       = obyte_r;
  assign out_valid      = ovalid_r;
  assign out_last       = olast_r;
  assign out_overflow   = oovf_r;
  assign out_length     = olen_r;

`ifndef ASSERT_OFF
  a_slot_range: assert property (@(posedge clk) disable iff (!rst_n)
    k_r != 2'd3)
    else $error("candidate index out of range");

  a_ovf_len: assert property (@(posedge clk) disable iff (!rst_n)
    (oitem_r && oovf_r) |-> (olast_r && olen_r == 16'd0))
    else $error("overflow result without last or with nonzero length");

  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (oitem_r && !ovalid_r) |-> olast_r)
    else $error("byteless result that is not final");

  a_stream_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (load && r_last) |=> (count_r == 16'd0 && !ovf_r && k_r == 2'd0))
    else $error("stream state not cleared after final result");
`endif

endmodule

>>> rtl/url_percent_decoder.sv
// URL percent decoder (form flavor) top level: front, queue and back.
// Depends on upd_pkg, upd_front, upd_fifo and upd_back.
//
// Takes one encoded byte per cycle while in_stall is low. Each transfer's
// decoded bytes (zero to three) are queued and leave the back end one result
// per cycle while out_stall is low; a byte that only yields a final status
// still gives one result, and none comes out when the output capacity drops
// the rest of an entry that does not end the stream. The QUEUE_DEPTH-entry
// queue absorbs bursts, and in_stall rises only when it is full. Results go
// out through a single output register. The capacity register is written
// through cfg_* and is ready every cycle.
module url_percent_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_out_capacity,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_last,
  output logic        out_item_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        out_valid,
  output logic        out_last,
  output logic        out_overflow,
  output logic [15:0] out_length
);

  localparam int EW = $bits(upd_pkg::entry_t);

  logic [15:0]     cap_r;
  logic            q_push, q_pop, q_empty, q_full;
  upd_pkg::entry_t push_entry, head;
  logic [EW-1:0]   head_bits;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 16'hFFFF;
    end else if (cfg_valid) begin
      cap_r <= cfg_out_capacity;
    end
  end

  upd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_byte    (in_byte),
    .in_last    (in_last),
    .q_full     (q_full),
    .push       (q_push),
    .push_entry (push_entry)
  );

  upd_fifo #(
    .WIDTH (EW),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .pop       (q_pop),
    .pop_data  (head_bits),
    .empty     (q_empty),
    .full      (q_full)
  );

  assign head = upd_pkg::entry_t'(head_bits);

  upd_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head           (head),
    .q_empty        (q_empty),
    .pop            (q_pop),
    .capacity       (cap_r),
    .out_item_valid (out_item_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_last       (out_last),
    .out_overflow   (out_overflow),
    .out_length     (out_length)
  );

endmodule

>>> verif/url_percent_decoder_tb.sv
// Self-checking testbench for url_percent_decoder: directed and random encoded
// streams, with random idle and stall gaps on both sides and capacity writes.
// Depends on upd_pkg and the url_percent_decoder RTL.
module url_percent_decoder_tb;

  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int TOTAL_ITEMS  = 260;

  typedef struct {
    bit [7:0]  data;
    bit        valid;
    bit        last;
    bit        ovf;
    bit [15:0] total;
  } decoded_t;

  class decode_scoreboard;
    decoded_t  decoded_q[$];
    int        errors;
    bit [15:0] capacity;
    bit [1:0]  held_cnt;
    bit [7:0]  held_char;
    bit [16:0] produced;
    bit        ovf_flag;
    int        step_n;

    function new();
      capacity  = 16'hFFFF;
      held_cnt  = 0;
      held_char = 0;
      produced  = 0;
      ovf_flag  = 0;
      errors    = 0;
    endfunction

    function void set_capacity(bit [15:0] val);
      capacity = val;
    endfunction

    // bit 4 set: not a hex digit
    function bit [4:0] nibble_of(bit [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, 4'(c - "0")};
      if (c >= "A" && c <= "F") return {1'b0, 4'(c - "A" + 8'd10)};
      if (c >= "a" && c <= "f") return {1'b0, 4'(c - "a" + 8'd10)};
      return 5'h10;
    endfunction

    function void push_byte(bit [7:0] b);
      if (ovf_flag) return;
      if (produced >= {1'b0, capacity}) begin
        ovf_flag = 1;
        return;
      end
      produced++;
      decoded_q.push_back('{data: b, valid: 1, last: 0, ovf: 0, total: 0});
      step_n++;
    endfunction

    function void plain_char(bit [7:0] b);
      if (b == upd_pkg::CH_PERCENT) held_cnt = 1;
      else if (b == upd_pkg::CH_PLUS) push_byte(upd_pkg::CH_SPACE);
      else push_byte(b);
    endfunction

    function void note_input(bit [7:0] b, bit fin);
      bit [4:0] v;
      bit [4:0] hv;
      int       idx;
      step_n = 0;
      v = nibble_of(b);
      hv = nibble_of(held_char);
      case (held_cnt)
        2'd0: plain_char(b);
        2'd1: begin
          if (!v[4]) begin
            held_char = b;
            held_cnt = 2;
          end else begin
            held_cnt = 0;
            push_byte(upd_pkg::CH_PERCENT);
            plain_char(b);
          end
        end
        default: begin
          held_cnt = 0;
          if (!v[4]) begin
            push_byte({hv[3:0], v[3:0]});
          end else begin
            push_byte(upd_pkg::CH_PERCENT);
            push_byte(held_char);
            plain_char(b);
          end
        end
      endcase
      if (fin) begin
        if (held_cnt >= 1) push_byte(upd_pkg::CH_PERCENT);
        if (held_cnt == 2) push_byte(held_char);
        if (step_n == 0) decoded_q.push_back('{data: 0, valid: 0, last: 0, ovf: 0, total: 0});
        idx = decoded_q.size() - 1;
        decoded_q[idx].last = 1;
        decoded_q[idx].ovf = ovf_flag;
        decoded_q[idx].total = ovf_flag ? 16'd0 : produced[15:0];
        held_cnt = 0;
        held_char = 0;
        produced = 0;
        ovf_flag = 0;
      end
    endfunction

    function void compare_result(decoded_t got);
      decoded_t exp;
      if (decoded_q.size() == 0) begin
        $display("%0t ERROR unexpected result: expected none, got byte=%h valid=%b last=%b",
                 $time, got.data, got.valid, got.last);
        errors++;
        return;
      end
      exp = decoded_q.pop_front();
      if (got.data != exp.data) begin
        $display("%0t ERROR out_byte: expected %h, got %h", $time, exp.data, got.data);
        errors++;
      end
      if (got.valid != exp.valid) begin
        $display("%0t ERROR out_valid: expected %b, got %b", $time, exp.valid, got.valid);
        errors++;
      end
      if (got.last != exp.last) begin
        $display("%0t ERROR out_last: expected %b, got %b", $time, exp.last, got.last);
        errors++;
      end
      if (got.ovf != exp.ovf) begin
        $display("%0t ERROR out_overflow: expected %b, got %b", $time, exp.ovf, got.ovf);
        errors++;
      end
      if (got.total != exp.total) begin
        $display("%0t ERROR out_length: expected %0d, got %0d", $time, exp.total, got.total);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_out_capacity;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  in_byte;
  logic        in_last;
  logic        out_item_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        out_valid;
  logic        out_last;
  logic        out_overflow;
  logic [15:0] out_length;

  decode_scoreboard tracker;
  bit quiet;
  int items_sent;
  int stall_left;
  int idle_cycles;

  url_percent_decoder DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_out_capacity(cfg_out_capacity),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_byte         (in_byte),
    .in_last         (in_last),
    .out_item_valid  (out_item_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_valid       (out_valid),
    .out_last        (out_last),
    .out_overflow    (out_overflow),
    .out_length      (out_length)
  );

  always #4 clk = ~clk;

  function automatic int draw_gap();
    return quiet ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic bit [7:0] random_hex_char();
    int r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'("0" + r);
    if (r < 16) return 8'("A" + r - 10);
    return 8'("a" + r - 16);
  endfunction

  task automatic send_byte(input bit [7:0] b, input bit fin);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (in_stall);
    tracker.note_input(b, fin);
    items_sent++;
  endtask

  task automatic send_stream(input bit [7:0] s[$], input bit close);
    int i;
    for (i = 0; i < s.size(); i++) send_byte(s[i], close && (i == s.size() - 1));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (tracker.decoded_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_capacity(input bit [15:0] val);
    wait_drained();
    cfg_valid        <= 1'b1;
    cfg_out_capacity <= val;
    do @(posedge clk); while (!cfg_ready);
    tracker.set_capacity(val);
    cfg_valid <= 1'b0;
  endtask

  // result side: accept, check, then hold off for a random gap from draw_gap()
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_item_valid && !out_stall) begin
        tracker.compare_result('{data: out_byte, valid: out_valid, last: out_last,
                                 ovf: out_overflow, total: out_length});
        stall_left = draw_gap();
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall <= (stall_left != 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_item_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("url_percent_decoder: mismatch");
      $finish;
    end
  end

  initial begin
    bit [7:0]  s[$];
    bit [15:0] cap;
    int        phase;
    int        phase_start;
    int        len;
    int        r;
    tracker          = new();
    quiet            = 0;
    items_sent       = 0;
    stall_left       = 0;
    idle_cycles      = 0;
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_out_capacity = '0;
    in_valid         = 1'b0;
    in_byte          = '0;
    in_last          = 1'b0;
    out_stall        = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // escapes in both cases, plus, byte extremes
    s = '{"%", "4", "1", "%", "6", "a", "+", 8'h00, 8'hFF};
    send_stream(s, 1);
    // broken escapes, dangling percent at the end
    s = '{"%", "g", "%", "4", "G", "%"};
    send_stream(s, 1);
    // percent and one digit held at the end
    s = '{"%", "F"};
    send_stream(s, 1);
    // capacity changed mid-stream, then overflow
    s = '{"a", "b"};
    send_stream(s, 0);
    write_capacity(16'd3);
    s = '{"c", "d"};
    send_stream(s, 1);
    // zero capacity: final transfer carries only the status
    write_capacity(16'd0);
    s = '{"x", "%"};
    send_stream(s, 1);

    phase = 0;
    while (items_sent < TOTAL_ITEMS) begin
      case (phase % 5)
        0: cap = 16'($urandom_range(1, 12));
        1: cap = 16'hFFFF;
        2: cap = 16'($urandom_range(13, 40));
        3: cap = 16'($urandom_range(0, 65535));
        default: cap = 16'($urandom_range(0, 2));
      endcase
      write_capacity(cap);
      quiet = ($urandom_range(0, 3) == 0);
      phase_start = items_sent;
      while (items_sent - phase_start < 40 && items_sent < TOTAL_ITEMS) begin
        s = {};
        len = $urandom_range(1, 10);
        while (s.size() < len) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            s.push_back(upd_pkg::CH_PERCENT);
            s.push_back(random_hex_char());
            s.push_back(random_hex_char());
          end else if (r < 50) begin
            s.push_back(upd_pkg::CH_PLUS);
          end else if (r < 60) begin
            s.push_back(upd_pkg::CH_PERCENT);
            s.push_back(random_hex_char());
            s.push_back(8'($urandom_range(0, 255)));
          end else if (r < 65) begin
            s.push_back(upd_pkg::CH_PERCENT);
          end else begin
            s.push_back(8'($urandom_range(0, 255)));
          end
        end
        send_stream(s, 1);
      end
      phase++;
    end

    wait_drained();
    if (tracker.errors == 0) begin
      $display("url_percent_decoder: match");
    end else begin
      $display("url_percent_decoder: mismatch");
    end
    $finish;
  end

endmodule
